FILE: hdl/svle_pkg.sv
`timescale 1ns / 1ps

package svle_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int OP_W = 3;
  localparam int VAL_W = 16;
  localparam int CNT_W = 6;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND = 3'd2;
  localparam logic [OP_W-1:0] OP_SORT_UP = 3'd3;
  localparam logic [OP_W-1:0] OP_SORT_DN = 3'd4;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP = 3'd6;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    CC_HOLD,
    CC_LOAD_FRONT,
    CC_TAKE_RIGHT,
    CC_SET_TAG,
    CC_EXCH
  } cell_cmd_t;

  typedef enum logic [1:0] {
    MD_UP,
    MD_DN,
    MD_REV
  } exch_mode_t;

  typedef struct packed {
    cell_cmd_t  cmd;
    logic       phase;
    exch_mode_t mode;
  } cell_ctrl_t;

endpackage

FILE: hdl/svle_in_if.sv
`timescale 1ns / 1ps

interface svle_in_if;
  logic                       valid;
  logic                       ready;
  logic [svle_pkg::OP_W-1:0]  op;
  logic [svle_pkg::VAL_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

FILE: hdl/svle_out_if.sv
`timescale 1ns / 1ps

interface svle_out_if;
  logic                       valid;
  logic                       ready;
  logic [svle_pkg::VAL_W-1:0] value_res;
  logic [svle_pkg::CNT_W-1:0] count;
  logic [svle_pkg::ST_W-1:0]  status;
  logic                       last;

  modport source (output valid, output value_res, output count, output status, output last,
                  input ready);
  modport sink (input valid, input value_res, input count, input status, input last,
                output ready);
endinterface

FILE: hdl/svle_cell.sv
`timescale 1ns / 1ps

module svle_cell #(
  parameter int IDX = 0,
  parameter int N = svle_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  svle_pkg::cell_ctrl_t       ctrl,
  input  logic [svle_pkg::VAL_W-1:0] left_val,
  input  logic [$clog2(N)-1:0]       left_tag,
  input  logic [svle_pkg::VAL_W-1:0] right_val,
  input  logic [$clog2(N)-1:0]       right_tag,
  output logic [svle_pkg::VAL_W-1:0] val,
  output logic [$clog2(N)-1:0]       tag
);

  localparam int TW = $clog2(N);
  localparam logic IS_ODD = 1'(IDX % 2);
  localparam bit HAS_LEFT = (IDX > 0);
  localparam bit HAS_RIGHT = (IDX < N - 1);

  logic [svle_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [TW-1:0]              tag_r, tag_nxt;

  function automatic logic swap_dec(input logic [svle_pkg::VAL_W-1:0] a_v,
                                    input logic [TW-1:0] a_t,
                                    input logic [svle_pkg::VAL_W-1:0] b_v,
                                    input logic [TW-1:0] b_t,
                                    input svle_pkg::exch_mode_t mode);
    logic s;
    case (mode)
      svle_pkg::MD_UP:  s = (b_v != '0) && ((a_v == '0) || (a_v > b_v));
      svle_pkg::MD_DN:  s = (b_v > a_v);
      svle_pkg::MD_REV: s = (a_v != '0) && (b_v != '0) && (a_t < b_t);
      default:          s = 1'b0;
    endcase
    return s;
  endfunction

  always_comb begin
    val_nxt = val_r;
    tag_nxt = tag_r;
    case (ctrl.cmd)
      svle_pkg::CC_LOAD_FRONT: val_nxt = left_val;
      svle_pkg::CC_TAKE_RIGHT: val_nxt = right_val;
      svle_pkg::CC_SET_TAG:    tag_nxt = TW'(IDX);
      svle_pkg::CC_EXCH: begin
        if (HAS_RIGHT && (IS_ODD == ctrl.phase)) begin
          if (swap_dec(val_r, tag_r, right_val, right_tag, ctrl.mode)) begin
            val_nxt = right_val;
            tag_nxt = right_tag;
          end
        end else if (HAS_LEFT && (IS_ODD != ctrl.phase)) begin
          if (swap_dec(left_val, left_tag, val_r, tag_r, ctrl.mode)) begin
            val_nxt = left_val;
            tag_nxt = left_tag;
          end
        end
      end
      default: begin
        val_nxt = val_r;
        tag_nxt = tag_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;
  assign tag = tag_r;

endmodule

FILE: hdl/sortable_value_list_engine.sv
// Insert, delete and unknown operations give their single result in the cycle after the request.
// Find, sort and reverse step the row of cells ENTRIES times, one step a cycle, and give
// their result from the done state once the output is free; the next request is taken after that.
// Dump rotates the row ENTRIES steps and gives one result a cycle while the sink takes them.
// Synchronous active-low reset clears every slot, the count and the control state at once.
`timescale 1ns / 1ps

module sortable_value_list_engine #(
  parameter int ENTRIES = svle_pkg::ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  svle_in_if.sink   in_ch,
  svle_out_if.source out_ch
);

  localparam int VW = svle_pkg::VAL_W;
  localparam int TW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [SW-1:0]                step_r, step_nxt;
  logic [svle_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [VW-1:0]                key_r, key_nxt;
  logic                         found_r, found_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         ov_r, ov_nxt;
  logic [VW-1:0]                res_val_r, res_val_nxt;
  logic [svle_pkg::CNT_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic [svle_pkg::ST_W-1:0]    res_st_r, res_st_nxt;
  logic                         res_last_r, res_last_nxt;

  svle_pkg::cell_ctrl_t ctrl;
  logic                 rot_sel;
  logic                 out_free;
  logic                 in_acc;
  logic                 last_step;

  logic [VW-1:0] cell_val [ENTRIES];
  logic [TW-1:0] cell_tag [ENTRIES];

  assign out_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign last_step = (step_r == SW'(ENTRIES - 1));

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    op_nxt = op_r;
    key_nxt = key_r;
    found_nxt = found_r;
    count_nxt = count_r;
    ov_nxt = ov_r && !out_ch.ready;
    res_val_nxt = res_val_r;
    res_cnt_nxt = res_cnt_r;
    res_st_nxt = res_st_r;
    res_last_nxt = res_last_r;
    ctrl.cmd = svle_pkg::CC_HOLD;
    ctrl.phase = step_r[0];
    ctrl.mode = (op_r == svle_pkg::OP_REVERSE) ? svle_pkg::MD_REV :
                (op_r == svle_pkg::OP_SORT_DN) ? svle_pkg::MD_DN : svle_pkg::MD_UP;
    rot_sel = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = in_ch.op;
          key_nxt = in_ch.value;
          found_nxt = 1'b0;
          step_nxt = '0;
          ov_nxt = 1'b1;
          res_val_nxt = '0;
          res_cnt_nxt = svle_pkg::CNT_W'(count_r);
          res_st_nxt = svle_pkg::ST_OK;
          res_last_nxt = 1'b1;
          case (in_ch.op)
            svle_pkg::OP_INSERT: begin
              if (in_ch.value != '0) begin
                if (count_r == CW'(ENTRIES)) begin
                  res_st_nxt = svle_pkg::ST_FULL;
                end else begin
                  ctrl.cmd = svle_pkg::CC_LOAD_FRONT;
                  count_nxt = count_r + CW'(1);
                  res_cnt_nxt = svle_pkg::CNT_W'(count_r + CW'(1));
                end
              end
            end
            svle_pkg::OP_DELETE: begin
              if (count_r == '0) begin
                res_st_nxt = svle_pkg::ST_EMPTY;
              end else begin
                ctrl.cmd = svle_pkg::CC_TAKE_RIGHT;
                count_nxt = count_r - CW'(1);
                res_val_nxt = cell_val[0];
                res_cnt_nxt = svle_pkg::CNT_W'(count_r - CW'(1));
              end
            end
            svle_pkg::OP_FIND, svle_pkg::OP_SORT_UP, svle_pkg::OP_SORT_DN: begin
              ov_nxt = 1'b0;
              state_nxt = S_RUN;
            end
            svle_pkg::OP_REVERSE: begin
              ov_nxt = 1'b0;
              ctrl.cmd = svle_pkg::CC_SET_TAG;
              state_nxt = S_RUN;
            end
            svle_pkg::OP_DUMP: begin
              if (count_r == '0) begin
                res_st_nxt = svle_pkg::ST_EMPTY;
              end else begin
                ov_nxt = 1'b0;
                state_nxt = S_RUN;
              end
            end
            default: begin
              res_st_nxt = svle_pkg::ST_OK;
            end
          endcase
        end
      end

      S_RUN: begin
        case (op_r)
          svle_pkg::OP_FIND: begin
            ctrl.cmd = svle_pkg::CC_TAKE_RIGHT;
            rot_sel = 1'b1;
            if ((key_r != '0) && (cell_val[0] == key_r)) begin
              found_nxt = 1'b1;
            end
          end
          svle_pkg::OP_DUMP: begin
            if (CW'(step_r) < count_r) begin
              if (out_free) begin
                ctrl.cmd = svle_pkg::CC_TAKE_RIGHT;
                rot_sel = 1'b1;
                ov_nxt = 1'b1;
                res_val_nxt = cell_val[0];
                res_cnt_nxt = svle_pkg::CNT_W'(count_r);
                res_st_nxt = svle_pkg::ST_OK;
                res_last_nxt = (CW'(step_r) + CW'(1) == count_r);
              end
            end else begin
              ctrl.cmd = svle_pkg::CC_TAKE_RIGHT;
              rot_sel = 1'b1;
            end
          end
          default: begin
            ctrl.cmd = svle_pkg::CC_EXCH;
          end
        endcase
        if (ctrl.cmd != svle_pkg::CC_HOLD) begin
          if (last_step) begin
            step_nxt = '0;
            state_nxt = (op_r == svle_pkg::OP_DUMP) ? S_IDLE : S_DONE;
          end else begin
            step_nxt = step_r + SW'(1);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          res_cnt_nxt = svle_pkg::CNT_W'(count_r);
          res_last_nxt = 1'b1;
          res_val_nxt = '0;
          res_st_nxt = svle_pkg::ST_OK;
          if (op_r == svle_pkg::OP_FIND) begin
            res_val_nxt = found_r ? key_r : '0;
            res_st_nxt = found_r ? svle_pkg::ST_OK : svle_pkg::ST_NOTFOUND;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    key_r <= key_nxt;
    res_val_r <= res_val_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_st_r <= res_st_nxt;
    res_last_r <= res_last_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      found_r <= 1'b0;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      found_r <= found_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [VW-1:0] lv, rv;
    logic [TW-1:0] lt, rt;
    if (i == 0) begin : g_head
      assign lv = in_ch.value;
      assign lt = '0;
    end else begin : g_mid_l
      assign lv = cell_val[i-1];
      assign lt = cell_tag[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign rv = rot_sel ? cell_val[0] : '0;
      assign rt = cell_tag[0];
    end else begin : g_mid_r
      assign rv = cell_val[i+1];
      assign rt = cell_tag[i+1];
    end
    svle_cell #(
      .IDX(i),
      .N  (ENTRIES)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .left_val (lv),
      .left_tag (lt),
      .right_val(rv),
      .right_tag(rt),
      .val      (cell_val[i]),
      .tag      (cell_tag[i])
    );
  end

  assign out_ch.valid = ov_r;
  assign out_ch.value_res = res_val_r;
  assign out_ch.count = res_cnt_r;
  assign out_ch.status = res_st_r;
  assign out_ch.last = res_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.op == svle_pkg::OP_INSERT) && (in_ch.value != '0) &&
    (count_r != CW'(ENTRIES)) |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the list");

  a_run_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |=> $stable(count_r))
    else $error("count changed during a multi-cycle request");

  a_front_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (count_r != '0) |-> cell_val[0] != '0)
    else $error("front slot empty in a non-empty list");

endmodule
